// ----- rtl/s_expression_lexer_assert.svh -----
`ifndef S_EXPRESSION_LEXER_ASSERT_SVH
`define S_EXPRESSION_LEXER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define SEXP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");

// next-cycle implication
`define SEXP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

// ----- rtl/sexp_lex_pkg.sv -----
package sexp_lex_pkg;

    localparam int DEF_MAX_DEPTH = 255;
    localparam int FIFO_DEPTH    = 4;
    localparam int LAMBDA_LEN    = 6;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_SEMI   = 8'h3b;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_STRING  = 3'd1,
        MODE_TEXT    = 3'd2,
        MODE_COMMA   = 3'd3,
        MODE_STOPPED = 3'd4
    } t_lex_mode;

    typedef enum logic [3:0] {
        KIND_NONE      = 4'd0,
        KIND_LPAREN    = 4'd1,
        KIND_RPAREN    = 4'd2,
        KIND_STRING    = 4'd3,
        KIND_QUOTE     = 4'd4,
        KIND_DOT       = 4'd5,
        KIND_BACKQUOTE = 4'd6,
        KIND_UNQUOTE   = 4'd7,
        KIND_SPLICE    = 4'd8,
        KIND_LAMBDA    = 4'd9,
        KIND_SYMBOL    = 4'd10
    } t_token_kind;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_mark;
    } t_in_item;

    typedef struct packed {
        t_token_kind token_kind;
        logic [7:0]  content_byte;
        logic        content_valid;
        logic        token_done;
        logic        lex_error;
        logic        last_of_run;
    } t_out_item;

    function automatic logic [7:0] lambda_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h6c;
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h6d;
            3'd3:    ch = 8'h62;
            3'd4:    ch = 8'h64;
            3'd5:    ch = 8'h61;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // returns {miss, match}
    function automatic logic [3:0] lambda_step(input logic [2:0] match, input logic miss,
                                               input logic [7:0] c);
        logic [3:0] res;
        if (!miss && match < 3'(LAMBDA_LEN) && c == lambda_char(match)) begin
            res = {1'b0, match + 3'd1};
        end else begin
            res = {1'b1, match};
        end
        return res;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic t_out_item mk_item(input t_token_kind kind, input logic [7:0] b,
                                          input logic valid, input logic done,
                                          input logic err);
        t_out_item it;
        it.token_kind    = kind;
        it.content_byte  = b;
        it.content_valid = valid;
        it.token_done    = done;
        it.lex_error     = err;
        it.last_of_run   = 1'b0;
        return it;
    endfunction

endpackage

// ----- rtl/s_expression_lexer.sv -----
// S-expression lexer.
// Input channel: i_in_valid / o_in_stall carry one character (or an end of
// text mark) per transaction in i_in_data. Output channel: o_out_valid /
// i_out_stall carry token items in o_out_data; last_of_run flags the final
// item caused by one input transaction.
// An input transaction lands in an input register; from there, once the
// output queue has room, it is lexed against the state and its zero to two
// items are written to a four-entry output queue, whose head drives
// o_out_data.
// Throughput: one character per cycle while every character yields at most
// one item and the receiver does not stall. A character yielding two items
// (token close plus a new token) puts both into the output queue, which is
// read at one item per cycle.
// Input is held off whenever the queue, after this cycle's read, has fewer
// than two free places, so stalling the receiver backs up into o_in_stall.
// Reset (synchronous, i_rst_n low) empties the queue and input register,
// clears the depth, the lambda match and the sticky error, and returns to
// the between-tokens state. After an error all input is taken and dropped.
`include "s_expression_lexer_assert.svh"

module s_expression_lexer
    import sexp_lex_pkg::*;
#(
    parameter int MAX_DEPTH = DEF_MAX_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_lex_mode      r_mode,   n_mode;
    logic [DW-1:0]  r_depth,  n_depth;
    logic [2:0]     r_lmatch, n_lmatch;
    logic           r_lmiss,  n_lmiss;
    logic           r_err,    n_err;

    logic           r_in_valid;
    t_in_item       r_in;

    t_out_item      r_fifo [FIFO_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_cnt;

    logic           pop;
    logic           consume;
    logic [CW-1:0]  level;
    logic [1:0]     wr_cnt;
    t_out_item      items [2];

    assign pop         = (r_cnt != '0) && !i_out_stall;
    assign level       = r_cnt - CW'(pop);
    assign consume     = r_in_valid && (level <= CW'(FIFO_DEPTH - 2));
    assign o_in_stall  = r_in_valid && !consume;
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_fifo[r_rd_ptr];

    always_comb begin
        logic [7:0] c;
        logic       do_idle;
        logic [1:0] cnt;
        logic [3:0] lam;
        c        = r_in.char_byte;
        do_idle  = 1'b0;
        cnt      = 2'd0;
        lam      = 4'd0;
        n_mode   = r_mode;
        n_depth  = r_depth;
        n_lmatch = r_lmatch;
        n_lmiss  = r_lmiss;
        n_err    = r_err;
        items[0] = mk_item(KIND_NONE, 8'h00, 1'b0, 1'b0, 1'b0);
        items[1] = mk_item(KIND_NONE, 8'h00, 1'b0, 1'b0, 1'b0);

        if (consume && !r_err) begin
            if (r_in.end_mark) begin
                unique case (r_mode)
                    MODE_TEXT: begin
                        items[cnt[0]] = mk_item((!r_lmiss && r_lmatch == 3'(LAMBDA_LEN))
                                                ? KIND_LAMBDA : KIND_SYMBOL,
                                                8'h00, 1'b0, 1'b1, 1'b0);
                        cnt = cnt + 2'd1;
                    end
                    MODE_COMMA: begin
                        items[cnt[0]] = mk_item(KIND_UNQUOTE, 8'h00, 1'b0, 1'b1, 1'b0);
                        cnt = cnt + 2'd1;
                    end
                    MODE_STRING: begin
                        n_err = 1'b1;
                        items[cnt[0]] = mk_item(KIND_NONE, 8'h00, 1'b0, 1'b0, 1'b1);
                        cnt = cnt + 2'd1;
                    end
                    default: begin
                    end
                endcase
                if (!n_err && r_depth != '0) begin
                    n_err = 1'b1;
                    items[cnt[0]] = mk_item(KIND_NONE, 8'h00, 1'b0, 1'b0, 1'b1);
                    cnt = cnt + 2'd1;
                end
                n_mode   = MODE_IDLE;
                n_depth  = '0;
                n_lmatch = 3'd0;
                n_lmiss  = 1'b0;
            end else begin
                unique case (r_mode)
                    MODE_STOPPED: begin
                    end
                    MODE_STRING: begin
                        if (c == CH_DQUOTE) begin
                            items[cnt[0]] = mk_item(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b0);
                            n_mode = MODE_IDLE;
                        end else begin
                            items[cnt[0]] = mk_item(KIND_STRING, c, 1'b1, 1'b0, 1'b0);
                        end
                        cnt = cnt + 2'd1;
                    end
                    MODE_TEXT: begin
                        if (c == CH_LPAREN || c == CH_RPAREN || c == CH_SPACE ||
                            c == CH_DQUOTE) begin
                            items[cnt[0]] = mk_item((!r_lmiss && r_lmatch == 3'(LAMBDA_LEN))
                                                    ? KIND_LAMBDA : KIND_SYMBOL,
                                                    8'h00, 1'b0, 1'b1, 1'b0);
                            n_mode  = MODE_IDLE;
                            do_idle = 1'b1;
                        end else begin
                            lam = lambda_step(r_lmatch, r_lmiss, c);
                            n_lmiss  = lam[3];
                            n_lmatch = lam[2:0];
                            items[cnt[0]] = mk_item(KIND_SYMBOL, c, 1'b1, 1'b0, 1'b0);
                        end
                        cnt = cnt + 2'd1;
                    end
                    MODE_COMMA: begin
                        if (c == CH_AT) begin
                            items[cnt[0]] = mk_item(KIND_SPLICE, 8'h00, 1'b0, 1'b1, 1'b0);
                            n_mode = MODE_IDLE;
                        end else begin
                            items[cnt[0]] = mk_item(KIND_UNQUOTE, 8'h00, 1'b0, 1'b1, 1'b0);
                            do_idle = 1'b1;
                        end
                        cnt = cnt + 2'd1;
                    end
                    default: begin
                        do_idle = 1'b1;
                    end
                endcase

                if (do_idle) begin
                    n_mode = MODE_IDLE;
                    if (!is_space(c)) begin
                        unique case (c)
                            CH_SEMI: begin
                                n_mode = MODE_STOPPED;
                            end
                            CH_LPAREN: begin
                                if (r_depth >= DW'(MAX_DEPTH)) begin
                                    n_err = 1'b1;
                                    items[cnt[0]] = mk_item(KIND_NONE, 8'h00, 1'b0, 1'b0,
                                                            1'b1);
                                end else begin
                                    n_depth = r_depth + DW'(1);
                                    items[cnt[0]] = mk_item(KIND_LPAREN, 8'h00, 1'b0, 1'b1,
                                                            1'b0);
                                end
                                cnt = cnt + 2'd1;
                            end
                            CH_RPAREN: begin
                                if (r_depth == '0) begin
                                    n_err = 1'b1;
                                    items[cnt[0]] = mk_item(KIND_NONE, 8'h00, 1'b0, 1'b0,
                                                            1'b1);
                                end else begin
                                    n_depth = r_depth - DW'(1);
                                    items[cnt[0]] = mk_item(KIND_RPAREN, 8'h00, 1'b0, 1'b1,
                                                            1'b0);
                                end
                                cnt = cnt + 2'd1;
                            end
                            CH_DQUOTE: begin
                                n_mode = MODE_STRING;
                            end
                            CH_SQUOTE: begin
                                items[cnt[0]] = mk_item(KIND_QUOTE, 8'h00, 1'b0, 1'b1, 1'b0);
                                cnt = cnt + 2'd1;
                            end
                            CH_DOT: begin
                                items[cnt[0]] = mk_item(KIND_DOT, 8'h00, 1'b0, 1'b1, 1'b0);
                                cnt = cnt + 2'd1;
                            end
                            CH_BTICK: begin
                                items[cnt[0]] = mk_item(KIND_BACKQUOTE, 8'h00, 1'b0, 1'b1,
                                                        1'b0);
                                cnt = cnt + 2'd1;
                            end
                            CH_COMMA: begin
                                n_mode = MODE_COMMA;
                            end
                            default: begin
                                n_mode   = MODE_TEXT;
                                lam      = lambda_step(3'd0, 1'b0, c);
                                n_lmiss  = lam[3];
                                n_lmatch = lam[2:0];
                                items[cnt[0]] = mk_item(KIND_SYMBOL, c, 1'b1, 1'b0, 1'b0);
                                cnt = cnt + 2'd1;
                            end
                        endcase
                    end
                end
            end
        end

        if (cnt == 2'd1) begin
            items[0].last_of_run = 1'b1;
        end else if (cnt == 2'd2) begin
            items[1].last_of_run = 1'b1;
        end
        wr_cnt = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_IDLE;
            r_depth    <= '0;
            r_lmatch   <= 3'd0;
            r_lmiss    <= 1'b0;
            r_err      <= 1'b0;
            r_in_valid <= 1'b0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_cnt      <= '0;
        end else begin
            if (consume) begin
                r_mode   <= n_mode;
                r_depth  <= n_depth;
                r_lmatch <= n_lmatch;
                r_lmiss  <= n_lmiss;
                r_err    <= n_err;
            end
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            r_wr_ptr <= r_wr_ptr + PW'(wr_cnt);
            r_rd_ptr <= r_rd_ptr + PW'(pop);
            r_cnt    <= r_cnt + CW'(wr_cnt) - CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (wr_cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= items[0];
        end
        if (wr_cnt == 2'd2) begin
            r_fifo[r_wr_ptr + PW'(1)] <= items[1];
        end
    end

    `SEXP_ASSERT_NOW(a_fifo_bound, 1'b1, r_cnt <= CW'(FIFO_DEPTH))
    `SEXP_ASSERT_NEXT(a_err_sticky, r_err, r_err)
    `SEXP_ASSERT_NOW(a_err_silent, r_err && consume, wr_cnt == 2'd0)
    `SEXP_ASSERT_NOW(a_depth_bound, 1'b1, r_depth <= DW'(MAX_DEPTH))

endmodule

// ----- sim/s_expression_lexer_test.sv -----
module s_expression_lexer_test;
    import sexp_lex_pkg::*;

    typedef struct {
        t_lex_mode  mode;
        logic [7:0] depth;
        logic [2:0] matched;
        logic       missed;
        logic       failed;
    } t_lex_state;

    typedef enum {
        FAULT_CLOSE,
        FAULT_STRING,
        FAULT_OPEN
    } t_fault;

    class token_scoreboard;
        localparam logic [47:0] LAMBDA_TEXT = "lambda";

        t_lex_state st;
        t_out_item  fresh[$];
        t_out_item  awaited_tokens[$];
        int         mismatches;
        int         taken;
        int         seen;

        function new();
            st.mode    = MODE_IDLE;
            st.depth   = '0;
            st.matched = '0;
            st.missed  = 1'b0;
            st.failed  = 1'b0;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function logic [7:0] lambda_byte(int idx);
            return LAMBDA_TEXT[47 - 8 * idx -: 8];
        endfunction

        function void add(t_token_kind k, logic [7:0] b, logic v, logic d);
            t_out_item it;
            if (fresh.size() >= 3) return;
            it.token_kind    = k;
            it.content_byte  = b;
            it.content_valid = v;
            it.token_done    = d;
            it.lex_error     = st.failed;
            it.last_of_run   = 1'b0;
            fresh.push_back(it);
        endfunction

        function void raise_fault();
            st.failed = 1'b1;
            add(KIND_NONE, 8'h00, 1'b0, 1'b0);
        endfunction

        function void text_byte(logic [7:0] c);
            if (!st.missed && st.matched < 3'd6 && c == lambda_byte(int'(st.matched)))
                st.matched = st.matched + 3'd1;
            else
                st.missed = 1'b1;
            add(KIND_SYMBOL, c, 1'b1, 1'b0);
        endfunction

        function void text_close();
            add((!st.missed && st.matched == 3'd6) ? KIND_LAMBDA : KIND_SYMBOL,
                8'h00, 1'b0, 1'b1);
            st.mode = MODE_IDLE;
        endfunction

        function void token_start(logic [7:0] c);
            st.mode = MODE_IDLE;
            if (is_blank(c)) return;
            case (c)
                CH_SEMI:   st.mode = MODE_STOPPED;
                CH_LPAREN: begin
                    if (int'(st.depth) >= DEF_MAX_DEPTH) begin
                        raise_fault();
                    end else begin
                        st.depth = st.depth + 8'd1;
                        add(KIND_LPAREN, 8'h00, 1'b0, 1'b1);
                    end
                end
                CH_RPAREN: begin
                    if (st.depth == 8'd0) begin
                        raise_fault();
                    end else begin
                        st.depth = st.depth - 8'd1;
                        add(KIND_RPAREN, 8'h00, 1'b0, 1'b1);
                    end
                end
                CH_DQUOTE: st.mode = MODE_STRING;
                CH_SQUOTE: add(KIND_QUOTE, 8'h00, 1'b0, 1'b1);
                CH_DOT:    add(KIND_DOT, 8'h00, 1'b0, 1'b1);
                CH_BTICK:  add(KIND_BACKQUOTE, 8'h00, 1'b0, 1'b1);
                CH_COMMA:  st.mode = MODE_COMMA;
                default: begin
                    st.mode    = MODE_TEXT;
                    st.matched = '0;
                    st.missed  = 1'b0;
                    text_byte(c);
                end
            endcase
        endfunction

        function void lex_predict(t_in_item it);
            t_out_item tail;
            fresh.delete();
            if (st.failed) return;
            if (it.end_mark) begin
                case (st.mode)
                    MODE_TEXT:   text_close();
                    MODE_COMMA:  add(KIND_UNQUOTE, 8'h00, 1'b0, 1'b1);
                    MODE_STRING: raise_fault();
                    default: ;
                endcase
                if (!st.failed && st.depth != 8'd0) raise_fault();
                st.mode    = MODE_IDLE;
                st.depth   = '0;
                st.matched = '0;
                st.missed  = 1'b0;
            end else begin
                case (st.mode)
                    MODE_STOPPED: ;
                    MODE_STRING: begin
                        if (it.char_byte == CH_DQUOTE) begin
                            add(KIND_STRING, 8'h00, 1'b0, 1'b1);
                            st.mode = MODE_IDLE;
                        end else begin
                            add(KIND_STRING, it.char_byte, 1'b1, 1'b0);
                        end
                    end
                    MODE_TEXT: begin
                        if (it.char_byte inside {CH_LPAREN, CH_RPAREN, CH_SPACE,
                                                 CH_DQUOTE}) begin
                            text_close();
                            token_start(it.char_byte);
                        end else begin
                            text_byte(it.char_byte);
                        end
                    end
                    MODE_COMMA: begin
                        if (it.char_byte == CH_AT) begin
                            add(KIND_SPLICE, 8'h00, 1'b0, 1'b1);
                            st.mode = MODE_IDLE;
                        end else begin
                            add(KIND_UNQUOTE, 8'h00, 1'b0, 1'b1);
                            token_start(it.char_byte);
                        end
                    end
                    default: token_start(it.char_byte);
                endcase
            end
            if (fresh.size() > 0) begin
                tail = fresh.pop_back();
                tail.last_of_run = 1'b1;
                fresh.push_back(tail);
            end
        endfunction

        // would this item trip the sticky error, or silence the text with parens open
        function bit unsafe(t_in_item it);
            t_lex_state saved;
            bit         bad;
            saved = st;
            lex_predict(it);
            bad = st.failed ||
                  (st.mode == MODE_STOPPED && saved.mode != MODE_STOPPED && st.depth != 8'd0);
            st = saved;
            fresh.delete();
            return bad;
        endfunction

        function void take_char(t_in_item it);
            taken++;
            lex_predict(it);
            foreach (fresh[i]) awaited_tokens.push_back(fresh[i]);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void verify_item(t_out_item got);
            t_out_item want;
            seen++;
            if (awaited_tokens.size() == 0) begin
                $error("token item with nothing expected: kind %0d byte %0d",
                       got.token_kind, got.content_byte);
                mismatches++;
                return;
            end
            want = awaited_tokens.pop_front();
            compare_field("token_kind", int'(want.token_kind), int'(got.token_kind));
            compare_field("content_byte", int'(want.content_byte), int'(got.content_byte));
            compare_field("content_valid", int'(want.content_valid),
                          int'(got.content_valid));
            compare_field("token_done", int'(want.token_done), int'(got.token_done));
            compare_field("lex_error", int'(want.lex_error), int'(got.lex_error));
            compare_field("last_of_run", int'(want.last_of_run), int'(got.last_of_run));
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;

    token_scoreboard sb = new();

    int     gap_pct;
    int     stall_pct;
    int     busy_items;
    t_fault fault;

    s_expression_lexer #(
        .MAX_DEPTH(DEF_MAX_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(negedge i_clk) begin
        out_stall = ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) sb.verify_item(out_data);
    end

    // one transaction; called and returns at a falling edge
    task automatic feed(input logic [7:0] c, input logic e);
        while ($urandom_range(0, 99) < gap_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        if (sb.st.mode != MODE_STOPPED && !sb.st.failed) busy_items++;
        in_valid           = 1'b1;
        in_data.char_byte  = c;
        in_data.end_mark   = e;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        sb.take_char(in_data);
        @(negedge i_clk);
    endtask

    task automatic feed_text(input string s);
        for (int i = 0; i < s.len(); i++) feed(s[i], 1'b0);
    endtask

    // keeps the stream clear of the sticky error
    task automatic lex(input logic [7:0] c, input logic e);
        t_in_item it;
        it.char_byte = c;
        it.end_mark  = e;
        if (sb.unsafe(it)) begin
            it.char_byte = CH_SPACE;
            it.end_mark  = 1'b0;
        end
        feed(it.char_byte, it.end_mark);
    endtask

    function automatic logic [7:0] symbol_byte();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (sb.is_blank(c) || c inside {CH_LPAREN, CH_RPAREN, CH_DQUOTE, CH_SQUOTE,
                                               CH_DOT, CH_BTICK, CH_COMMA, CH_SEMI});
        return c;
    endfunction

    function automatic logic [7:0] blank_byte();
        int n;
        n = $urandom_range(0, 5);
        return (n == 5) ? CH_SPACE : CH_TAB + 8'(n);
    endfunction

    task automatic close_text();
        if (sb.st.mode == MODE_STRING) lex(CH_DQUOTE, 1'b0);
        while (sb.st.depth != 8'd0 && sb.st.mode != MODE_STOPPED) lex(CH_RPAREN, 1'b0);
        lex(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic pause_until_drained();
        in_valid = 1'b0;
        while (sb.awaited_tokens.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic random_token();
        int         n;
        logic [7:0] c;
        case ($urandom_range(0, 11))
            0, 1: if (sb.st.depth < 8'd12) lex(CH_LPAREN, 1'b0);
            2: if (sb.st.depth != 8'd0) lex(CH_RPAREN, 1'b0);
            3: begin
                lex(CH_DQUOTE, 1'b0);
                repeat ($urandom_range(0, 6)) begin
                    c = 8'($urandom_range(0, 255));
                    lex((c == CH_DQUOTE) ? ~c : c, 1'b0);
                end
                lex(CH_DQUOTE, 1'b0);
            end
            4: begin
                repeat ($urandom_range(1, 6)) lex(symbol_byte(), 1'b0);
                if ($urandom_range(0, 3) != 0) lex(CH_SPACE, 1'b0);
            end
            5: begin
                n = $urandom_range(4, 7);
                for (int i = 0; i < n; i++) begin
                    lex((i < 6) ? sb.lambda_byte(i) : symbol_byte(), 1'b0);
                end
                if ($urandom_range(0, 3) != 0) lex(CH_SPACE, 1'b0);
            end
            6: begin
                n = $urandom_range(0, 2);
                lex((n == 0) ? CH_SQUOTE : (n == 1) ? CH_DOT : CH_BTICK, 1'b0);
            end
            7: begin
                lex(CH_COMMA, 1'b0);
                if ($urandom_range(0, 1)) lex(CH_AT, 1'b0);
            end
            8: repeat ($urandom_range(1, 3)) lex(blank_byte(), 1'b0);
            9: lex(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0));
            10: begin
                if (sb.st.depth == 8'd0 && sb.st.mode != MODE_STRING) begin
                    lex(CH_SEMI, 1'b0);
                    repeat ($urandom_range(0, 4)) lex(8'($urandom_range(0, 255)), 1'b0);
                    close_text();
                end
            end
            default: close_text();
        endcase
    endtask

    initial begin
        int target;
        in_valid  = 1'b0;
        in_data   = '0;
        i_rst_n   = 1'b0;
        gap_pct   = 0;
        stall_pct = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // lambda, strings at both byte extremes, splice and plain unquote,
        // NUL-led run holding tab and semicolon, quote marks, comma then end,
        // ignored text after a comment, run flushed by end of text
        feed_text("(lambda \"");
        feed(8'hff, 1'b0);
        feed(8'h00, 1'b0);
        feed_text("\",@,");
        feed(8'h00, 1'b0);
        feed(CH_TAB, 1'b0);
        feed_text(";)'.`,");
        feed(8'hff, 1'b1);
        feed_text(";x");
        feed(8'h00, 1'b1);
        feed_text("q");
        feed(8'h00, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 55; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 55; end
                default: begin gap_pct = 13; stall_pct = 13; end
            endcase
            target = busy_items + 28;
            while (busy_items < target) random_token();
            close_text();
            pause_until_drained();
        end

        // one sticky fault per run, then input that must be dropped
        fault = t_fault'($urandom_range(0, 2));
        case (fault)
            FAULT_CLOSE: feed(CH_RPAREN, 1'b0);
            FAULT_STRING: begin
                feed(CH_DQUOTE, 1'b0);
                feed(symbol_byte(), 1'b0);
                feed(8'($urandom_range(0, 255)), 1'b1);
            end
            default: begin
                feed(CH_LPAREN, 1'b0);
                feed(symbol_byte(), 1'b0);
                feed(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
        repeat (8) feed(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        in_valid = 1'b0;

        while (sb.awaited_tokens.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.awaited_tokens.size() != 0) begin
            $error("%0d token items never arrived", sb.awaited_tokens.size());
            sb.mismatches += sb.awaited_tokens.size();
        end

        $display("Lexed %0d transactions and compared %0d token items under four flow-control mixes",
                 sb.taken, sb.seen);
        $display("Closing fault case: %s", fault.name());
        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
